/* hdl/rtc_pkg.sv */
// Package for the CMOS real-time clock: item types, action codes, register indices,
// BCD helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rtc_pkg;

	localparam int RamEntries = 64;
	localparam int RamAw = $clog2(RamEntries);

	typedef enum logic [2:0] {
		ACT_SELECT = 3'd0,
		ACT_WRITE  = 3'd1,
		ACT_READ   = 3'd2,
		ACT_PTICK  = 3'd3,
		ACT_UTICK  = 3'd4
	} action_t;

	localparam logic [5:0] R_SEC   = 6'h00;
	localparam logic [5:0] R_ASEC  = 6'h01;
	localparam logic [5:0] R_MIN   = 6'h02;
	localparam logic [5:0] R_AMIN  = 6'h03;
	localparam logic [5:0] R_HOUR  = 6'h04;
	localparam logic [5:0] R_AHOUR = 6'h05;
	localparam logic [5:0] R_WDAY  = 6'h06;
	localparam logic [5:0] R_MDAY  = 6'h07;
	localparam logic [5:0] R_MON   = 6'h08;
	localparam logic [5:0] R_YEAR  = 6'h09;
	localparam logic [5:0] R_STA   = 6'h0a;
	localparam logic [5:0] R_STB   = 6'h0b;
	localparam logic [5:0] R_STC   = 6'h0c;
	localparam logic [5:0] R_STD   = 6'h0d;
	localparam logic [5:0] R_0F    = 6'h0f;
	localparam logic [5:0] R_CENT1 = 6'h32;
	localparam logic [5:0] R_CENT2 = 6'h37;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_pulse;
		logic       nmi_disabled;
	} out_item_t;

	// binary 0..1023 to BCD tens/units truncated to 8 bits
	function automatic logic [7:0] enc8(input logic [9:0] v, input logic bcd);
		logic [9:0] t;
		logic [9:0] u;
		t = 10'((18'(v) * 18'd205) >> 11);
		u = v - 10'(t * 10'd10);
		return bcd ? {t[3:0], u[3:0]} : v[7:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/rtc_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rtc_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

/* hdl/rtc_calendar.sv */
// Next-second calendar step: seconds through year with leap years.
// Depends on rtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtc_calendar import rtc_pkg::*; (
	input  wire logic [5:0]  sec,
	input  wire logic [5:0]  min,
	input  wire logic [4:0]  hour,
	input  wire logic [7:0]  wday,
	input  wire logic [4:0]  mday,
	input  wire logic [3:0]  mon,
	input  wire logic [15:0] year,
	input  wire logic        leap,
	output logic      [5:0]  sec_n,
	output logic      [5:0]  min_n,
	output logic      [4:0]  hour_n,
	output logic      [7:0]  wday_n,
	output logic      [4:0]  mday_n,
	output logic      [3:0]  mon_n,
	output logic      [15:0] year_n
);
	logic [3:0] m;
	logic [4:0] mdays;

	always_comb begin
		sec_n = sec; min_n = min; hour_n = hour; wday_n = wday;
		mday_n = mday; mon_n = mon; year_n = year;
		m = (mon < 4'd1 || mon > 4'd12) ? 4'd1 : mon;
		case (m)
			4'd2:                      mdays = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: mdays = 5'd30;
			default:                   mdays = 5'd31;
		endcase
		if (sec < 6'd59) sec_n = sec + 6'd1;
		else begin
			sec_n = '0;
			if (min < 6'd59) min_n = min + 6'd1;
			else begin
				min_n = '0;
				if (hour < 5'd23) hour_n = hour + 5'd1;
				else begin
					hour_n = '0;
					wday_n = (wday >= 8'd7) ? 8'd1 : wday + 8'd1;
					mon_n = m;
					if (mday >= 5'd1 && mday < mdays) mday_n = mday + 5'd1;
					else begin
						mday_n = 5'd1;
						if (m < 4'd12) mon_n = m + 4'd1;
						else begin
							mon_n = 4'd1;
							year_n = year + 16'd1;
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/cmos_real_time_clock.sv */
// Top level of the CMOS real-time clock.
// Depends on rtc_pkg, rtc_calendar, rtc_ram.
// One item accepted per cycle; the result strobe done is registered through v_s1 and then the done register.
// busy is tied low; the RAM read port plus the result register set the latency.
// Reset: asynchronous, active low; registers take their power-on values, RAM is
// cleared by written-flags in flip-flops (all zero after reset). Results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module cmos_real_time_clock import rtc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire in_item_t  item_in,
	output logic           done,
	output out_item_t      result
);
	logic [5:0]  idx_q, sec_q, min_q, asec_q, amin_q;
	logic        nmi_q, std_q, ack_q;
	logic [4:0]  hour_q, ahour_q, mday_q;
	logic [7:0]  wday_q, stb_q;
	logic [3:0]  mon_q;
	logic [15:0] year_q;
	logic [6:0]  sta_q;
	logic [2:0]  stc_q;
	logic [RamEntries-1:0] wr_q;

	// stage 1 registers
	logic        v_s1, ram_s1, irq_s1, nmi_s1;
	logic [7:0]  rd_s1;
	logic [7:0]  ram_rdata;

	logic [6:0]  yr_lo;
	logic [9:0]  hund;
	logic        leap;
	logic [5:0]  sec_n, min_n;
	logic [4:0]  hour_n, mday_n;
	logic [7:0]  wday_n;
	logic [3:0]  mon_n;
	logic [15:0] year_n;

	logic        acc, bcd, time_reg, drop, hok;
	logic [7:0]  v, hv, wv, rd_c;
	logic [4:0]  hset;
	logic        ram_we, ram_rd, irq_c;
	logic [2:0]  flags_c;
	logic [RamAw-1:0] ram_a;
	logic [7:0]  ram_wd;
	logic [5:0]  r;
	action_t     act;

	assign busy = 1'b0;
	assign acc = start;
	assign r = idx_q;
	assign act = action_t'(item_in.action);
	assign bcd = ~stb_q[2];
	// year split: year / 100 as (year / 4) / 25 via reciprocal
	assign hund = 10'(((32'(year_q) >> 2) * 32'd5243) >> 17);
	assign yr_lo = 7'(year_q - 16'(hund) * 16'd100);
	assign leap = (year_q[1:0] == 2'd0) && ((yr_lo != 7'd0) || (hund[1:0] == 2'd0));

	rtc_calendar u_cal (
		.sec(sec_q), .min(min_q), .hour(hour_q), .wday(wday_q), .mday(mday_q),
		.mon(mon_q), .year(year_q), .leap(leap),
		.sec_n(sec_n), .min_n(min_n), .hour_n(hour_n), .wday_n(wday_n),
		.mday_n(mday_n), .mon_n(mon_n), .year_n(year_n)
	);

	always_comb begin
		time_reg = (r <= R_YEAR) || r == R_CENT1 || r == R_CENT2;
		drop = 1'b0;
		wv = item_in.data;
		v = wv;
		if (time_reg && bcd) begin
			if (wv[7:4] > 4'd9 || wv[3:0] > 4'd9) drop = 1'b1;
			if ((r == R_HOUR || r == R_AHOUR) && wv[7])
				v = (wv[7:4] == 4'd8) ? {4'h8, wv[3:0]} : 8'h8a + {4'd0, wv[3:0]};
			else
				v = 8'({4'd0, wv[7:4]} * 8'd10) + {4'd0, wv[3:0]};
		end
		hv = v; hok = 1'b1;
		if (!stb_q[1]) begin
			if ((v > 8'd12 && v < 8'h81) || v > 8'h8c) hok = 1'b0;
			if (v == 8'h8c) hv = 8'd12;
			else if (v > 8'd12) hv = v - 8'h74;
		end else if (v > 8'd23) hok = 1'b0;
		hset = hv[4:0];
	end

	always_comb begin
		rd_c = '0; ram_rd = 1'b0; ram_we = 1'b0;
		ram_a = RamAw'(r); ram_wd = v;
		if (acc && act == ACT_WRITE && !drop &&
			!(time_reg || r == R_STA || r == R_STB || r == R_STC || r == R_STD)) begin
			ram_we = 1'b1;
			if (r == R_0F) ram_wd = {1'b0, v[6:0]};
		end
		case (r)
			R_SEC:   rd_c = enc8({4'b0, sec_q}, bcd);
			R_ASEC:  rd_c = enc8({4'b0, asec_q}, bcd);
			R_MIN:   rd_c = enc8({4'b0, min_q}, bcd);
			R_AMIN:  rd_c = enc8({4'b0, amin_q}, bcd);
			R_HOUR:  rd_c = enc8({5'b0, hour_q}, bcd);
			R_AHOUR: rd_c = enc8({5'b0, ahour_q}, bcd);
			R_WDAY:  rd_c = enc8({2'b0, wday_q}, bcd);
			R_MDAY:  rd_c = enc8({5'b0, mday_q}, bcd);
			R_MON:   rd_c = enc8({6'b0, mon_q}, bcd);
			R_YEAR:  rd_c = enc8({3'b0, yr_lo}, bcd);
			R_CENT1, R_CENT2: rd_c = enc8(hund, bcd);
			R_STA:   rd_c = {1'b0, sta_q};
			R_STB:   rd_c = stb_q;
			R_STC:   rd_c = {|({1'b0, stc_q, 4'b0} & stb_q & 8'h70), stc_q, 4'b0};
			R_STD:   rd_c = {std_q, 7'b0};
			default: begin
				if (r inside {6'h10, 6'h12, 6'h39, 6'h3a, [6'h19:6'h2c]}) rd_c = '0;
				else ram_rd = 1'b1;
			end
		endcase
	end

	// flag update and interrupt for tick items
	always_comb begin
		flags_c = stc_q;
		if (act == ACT_PTICK) begin
			if (stb_q[6]) flags_c[2] = 1'b1;
		end else if (act == ACT_UTICK) begin
			if (!stb_q[7] && stb_q[5] && sec_n == asec_q && min_n == amin_q &&
				hour_n == ahour_q) flags_c[1] = 1'b1;
			if (stb_q[4]) flags_c[0] = 1'b1;
		end
		irq_c = (act == ACT_PTICK || act == ACT_UTICK) && ack_q && (flags_c != 3'd0);
	end

	rtc_ram #(.Width(8), .Depth(RamEntries)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 6'h0a; nmi_q <= 1'b0;
			sec_q <= '0; min_q <= '0; hour_q <= '0;
			wday_q <= 8'd1; mday_q <= 5'd1; mon_q <= 4'd1; year_q <= 16'd1980;
			asec_q <= '0; amin_q <= '0; ahour_q <= '0;
			sta_q <= 7'h26; stb_q <= 8'h02; stc_q <= '0; std_q <= 1'b1; ack_q <= 1'b1;
			wr_q <= '0;
			v_s1 <= 1'b0; ram_s1 <= 1'b0; irq_s1 <= 1'b0; nmi_s1 <= 1'b0;
			rd_s1 <= '0;
			done <= 1'b0; result <= '0;
		end else begin
			v_s1 <= acc;
			irq_s1 <= 1'b0;
			ram_s1 <= 1'b0;
			rd_s1 <= '0;
			if (acc) begin
				case (act)
					ACT_SELECT: begin
						idx_q <= item_in.data[5:0];
						nmi_q <= item_in.data[7];
					end
					ACT_WRITE: begin
						if (ram_we) wr_q[ram_a] <= 1'b1;
						if (!drop) case (r)
							R_SEC:   if (v <= 8'd59) sec_q <= v[5:0];
							R_ASEC:  if (v <= 8'd59) asec_q <= v[5:0];
							R_MIN:   if (v <= 8'd59) min_q <= v[5:0];
							R_AMIN:  if (v <= 8'd59) amin_q <= v[5:0];
							R_HOUR:  if (hok) hour_q <= hset;
							R_AHOUR: if (hok) ahour_q <= hset;
							R_WDAY:  wday_q <= v;
							R_MDAY:  if (v <= 8'd31) mday_q <= v[4:0];
							R_MON:   if (v >= 8'd1 && v <= 8'd12) mon_q <= v[3:0];
							R_YEAR:  year_q <= year_q - 16'(yr_lo) + 16'(v);
							R_CENT1, R_CENT2:
								if (v >= 8'd19)
									year_q <= 16'(yr_lo) + 16'(v) * 16'd100;
							R_STA:   sta_q <= v[6:0];
							R_STB:   stb_q <= v[7] ? (v & 8'hef) : v;
							R_STD:   std_q <= v[7];
							default: ;
						endcase
					end
					ACT_READ: begin
						rd_s1 <= rd_c;
						ram_s1 <= ram_rd && wr_q[ram_a];
						if (r == R_STC) begin
							stc_q <= '0;
							ack_q <= 1'b1;
						end
					end
					ACT_PTICK, ACT_UTICK: begin
						if (act == ACT_UTICK && !stb_q[7]) begin
							sec_q <= sec_n; min_q <= min_n; hour_q <= hour_n;
							wday_q <= wday_n; mday_q <= mday_n; mon_q <= mon_n;
							year_q <= year_n;
						end
						stc_q <= flags_c;
						if (irq_c) ack_q <= 1'b0;
						irq_s1 <= irq_c;
					end
					default: ;
				endcase
				nmi_s1 <= (act == ACT_SELECT) ? item_in.data[7] : nmi_q;
			end
			done <= v_s1;
			result.read_data <= ram_s1 ? ram_rdata : rd_s1;
			result.irq_pulse <= irq_s1;
			result.nmi_disabled <= nmi_s1;
		end
	end
endmodule
`default_nettype wire
